[hw/rtl/particle_pool_update_defines.svh]
// assertion macros for the particle pool
`ifndef PARTICLE_POOL_UPDATE_DEFINES_SVH
`define PARTICLE_POOL_UPDATE_DEFINES_SVH
`define PPU_ASSERT_IMP(lbl, clk, rst, a, c) lbl: assert property (@(posedge clk) \
  disable iff (rst) (a) |-> (c)) else $error("assertion failed");
`define PPU_ASSERT_NXT(lbl, clk, rst, a, c) lbl: assert property (@(posedge clk) \
  disable iff (rst) (a) |=> (c)) else $error("assertion failed");
`endif

[hw/rtl/ppu_pkg.sv]
// ----------------------------------------------------------------------------
// ppu_pkg
// shared constants and types of the particle pool
// ----------------------------------------------------------------------------
package ppu_pkg;
  localparam int Particles = 64;
  localparam int SlotW = 6;
  typedef enum logic [1:0] {OP_SPAWN = 2'd0, OP_TICK = 2'd1, OP_DRAW = 2'd2,
                            OP_NONE = 2'd3} op_t;
  typedef enum logic [1:0] {K_SPAWN = 2'd0, K_TICK = 2'd1, K_REC = 2'd2,
                            K_EMPTY = 2'd3} kind_t;
  // life 18, px 32, py 32, pz 32, vx 16, vy 16, vz 18, gray 17
  typedef struct packed {
    logic signed [17:0] life;
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] pz;
    logic signed [15:0] vx;
    logic signed [15:0] vy;
    logic signed [17:0] vz;
    logic [16:0] gray;
  } part_t;
  localparam int PartW = $bits(part_t);
endpackage

[hw/rtl/particle_pool_update.sv]
// ----------------------------------------------------------------------------
// particle_pool_update
// particle pool with spawn search, time tick and draw readout
// ----------------------------------------------------------------------------
// One item at a time; busy is high while it runs. After reset a clear pass
// writes zero to all 64 slots before start is taken. Each slot visit reads
// the particle ram, waits for the registered read, then computes and, for a
// tick, writes back. Spawn searches slots until it finds a free one or has
// seen all, then writes the new particle in a load state; tick visits every
// slot, draw every slot and then a load. Results appear on a one-cycle
// strobe and cannot be held off; draw gives one word per visible particle,
// each as the next is found or the last at the end, or one empty word.
module particle_pool_update (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  logic [1:0]          op,
  input  logic [15:0]         dt,
  input  logic signed [31:0]  spawn_x,
  input  logic signed [31:0]  spawn_y,
  input  logic signed [31:0]  spawn_z,
  input  logic [6:0]          rand_vx,
  input  logic [6:0]          rand_vy,
  input  logic [6:0]          rand_vz,
  input  logic [6:0]          rand_gray,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic                cfg_data,
  output logic                strobe,
  output logic [1:0]          kind,
  output logic [5:0]          slot,
  output logic signed [31:0]  pos_x,
  output logic signed [31:0]  pos_y,
  output logic signed [31:0]  pos_z,
  output logic [16:0]         gray,
  output logic [6:0]          alive_count,
  output logic                last
);
  import ppu_pkg::*;

  localparam logic [25:0] RecipVel = 26'(((64'd1 << 31) + 64'd199) / 64'd200);
  localparam logic [25:0] RecipVz = 26'(((64'd1 << 31) + 64'd49) / 64'd50);
  localparam logic [25:0] RecipGray = 26'(((64'd1 << 31) + 64'd99) / 64'd100);
  localparam logic [17:0] RecipTen = 18'(((64'd1 << 21) + 64'd9) / 64'd10);

  typedef enum logic [2:0] {S_CLR, S_IDLE, S_RD, S_WAIT, S_EXEC, S_LOAD} state_t;
  state_t state;
  logic [SlotW-1:0] idx, search_start, first_idx;
  logic [1:0] cur_op;
  logic [15:0] cur_dt;
  logic signed [31:0] sx, sy, sz;
  logic signed [17:0] vx_c, vy_c, vz_c;
  logic [16:0] g_c;
  logic fall;
  logic [6:0] alive;
  logic found;
  logic [SlotW-1:0] hold_slot;
  logic signed [31:0] hold_x, hold_y, hold_z;
  logic [16:0] hold_g;
  logic [16:0] dec, ginc;
  logic we;
  logic [SlotW-1:0] addr;
  part_t wdata, rd, upd;

  ppu_ram #(.Width(PartW), .Depth(Particles)) u_ram (
    .clk(clk), .we(we), .addr(addr), .wdata(wdata), .rdata(rd));

  assign busy = (state != S_IDLE);
  assign cfg_ready = (state == S_IDLE);

  // round(n * 65536 / den) half away from zero, by reciprocal multiply
  function automatic logic signed [18:0] rnd(input logic signed [8:0] n,
                                             input logic [6:0] half,
                                             input logic [25:0] recip);
    logic [6:0] mag;
    logic [22:0] x;
    logic [48:0] prod;
    logic [17:0] q;
    mag = n[8] ? 7'(-n) : 7'(n);
    x = {mag, 16'd0} + {16'd0, half};
    prod = {26'd0, x} * {23'd0, recip};
    q = prod[48:31];
    rnd = n[8] ? -$signed({1'b0, q}) : $signed({1'b0, q});
  endfunction

  function automatic logic signed [31:0] mv(input logic signed [31:0] p,
                                            input logic signed [17:0] v,
                                            input logic [15:0] t);
    logic signed [34:0] prod;
    logic signed [18:0] d;
    logic signed [32:0] r;
    prod = v * $signed({1'b0, t});
    d = 19'(prod >>> 16);
    r = 33'(p) - 33'(d);
    if (r > 33'sh0_7FFF_FFFF) mv = 32'sh7FFF_FFFF;
    else if (r < -33'sh0_8000_0000) mv = 32'sh8000_0000;
    else mv = r[31:0];
  endfunction

  logic signed [8:0] rz;
  logic signed [18:0] vx_n, vy_n, vz_n, gr_n;
  logic signed [17:0] vz_s;
  logic [16:0] gsum;
  logic [34:0] gprod;
  always_comb begin
    rz = fall ? -$signed({2'b0, rand_vz}) : $signed({2'b0, rand_vz});
    vx_n = rnd(9'sd50 - $signed({2'b0, rand_vx}), 7'd100, RecipVel);
    vy_n = rnd(9'sd50 - $signed({2'b0, rand_vy}), 7'd100, RecipVel);
    vz_n = rnd(rz, 7'd25, RecipVz);
    gr_n = rnd($signed({2'b0, rand_gray}), 7'd50, RecipGray);
    if (vz_n > 19'sd131071) vz_s = 18'sh1FFFF;
    else if (vz_n < -19'sd131072) vz_s = 18'sh20000;
    else vz_s = vz_n[17:0];
    gsum = 17'(dt) + 17'd5;
    gprod = {18'd0, gsum} * {17'd0, RecipTen};
  end

  logic signed [18:0] life_n;
  logic [17:0] g_n;
  always_comb begin
    upd = rd;
    life_n = 19'(rd.life) - $signed({2'b0, dec});
    if (life_n < -19'sd131072) life_n = -19'sd131072;
    upd.life = life_n[17:0];
    g_n = {1'b0, rd.gray} + {1'b0, ginc};
    if (life_n > 0) begin
      upd.px = mv(rd.px, 18'(rd.vx), cur_dt);
      upd.py = mv(rd.py, 18'(rd.vy), cur_dt);
      upd.pz = mv(rd.pz, rd.vz, cur_dt);
      upd.gray = g_n[17] ? 17'h1FFFF : g_n[16:0];
    end
  end

  always_comb begin
    we = 1'b0;
    addr = idx;
    wdata = upd;
    if (state == S_CLR) begin
      we = 1'b1;
      wdata = '0;
    end else if (state == S_EXEC && cur_op == OP_TICK) begin
      we = 1'b1;
    end else if (state == S_LOAD && cur_op == OP_SPAWN) begin
      we = 1'b1;
      wdata.life = 18'sd65536;
      wdata.px = sx;
      wdata.py = sy;
      wdata.pz = sz;
      wdata.vx = vx_c[15:0];
      wdata.vy = vy_c[15:0];
      wdata.vz = vz_c;
      wdata.gray = g_c;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLR;
      idx <= '0;
      search_start <= '0;
      fall <= 1'b0;
      strobe <= 1'b0;
    end else begin
      strobe <= 1'b0;
      case (state)
        S_CLR: begin
          idx <= idx + 1'b1;
          if (idx == SlotW'(Particles - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (cfg_valid) begin
            fall <= cfg_data;
          end
          if (start && op != OP_NONE) begin
            cur_op <= op;
            cur_dt <= dt;
            dec <= (17'(dt) + 17'd1) >> 1;
            ginc <= 17'(gprod[34:21]);
            sx <= spawn_x;
            sy <= spawn_y;
            sz <= spawn_z;
            vx_c <= vx_n[17:0];
            vy_c <= vy_n[17:0];
            vz_c <= vz_s;
            g_c <= gr_n[16:0];
            idx <= (op == OP_SPAWN) ? search_start : '0;
            first_idx <= search_start;
            alive <= '0;
            found <= 1'b0;
            state <= S_RD;
          end
        end
        S_RD: state <= S_WAIT;
        S_WAIT: state <= S_EXEC;
        S_EXEC: begin
          state <= S_RD;
          case (cur_op)
            OP_SPAWN: begin
              if (rd.life <= 0) begin
                search_start <= idx;
                state <= S_LOAD;
              end else if (SlotW'(idx + 1'b1) == first_idx ||
                           (idx == SlotW'(Particles - 1) && first_idx == '0)) begin
                idx <= '0;
                search_start <= '0;
                state <= S_LOAD;
              end else begin
                idx <= (idx == SlotW'(Particles - 1)) ? '0 : idx + 1'b1;
              end
            end
            OP_TICK: begin
              if (life_n > 0) alive <= alive + 1'b1;
              idx <= idx + 1'b1;
              if (idx == SlotW'(Particles - 1)) begin
                strobe <= 1'b1;
                kind <= K_TICK;
                slot <= '0;
                pos_x <= '0;
                pos_y <= '0;
                pos_z <= '0;
                gray <= '0;
                alive_count <= (life_n > 0) ? alive + 1'b1 : alive;
                last <= 1'b1;
                state <= S_IDLE;
              end
            end
            default: begin
              idx <= idx + 1'b1;
              if (rd.life > 18'sd655) begin
                if (found) begin
                  strobe <= 1'b1;
                  kind <= K_REC;
                  slot <= hold_slot;
                  pos_x <= hold_x;
                  pos_y <= hold_y;
                  pos_z <= hold_z;
                  gray <= hold_g;
                  alive_count <= '0;
                  last <= 1'b0;
                end
                found <= 1'b1;
                hold_slot <= idx;
                hold_x <= rd.px;
                hold_y <= rd.py;
                hold_z <= rd.pz;
                hold_g <= rd.gray;
              end
              if (idx == SlotW'(Particles - 1)) begin
                state <= S_LOAD;
              end
            end
          endcase
        end
        S_LOAD: begin
          state <= S_IDLE;
          strobe <= 1'b1;
          last <= 1'b1;
          alive_count <= '0;
          if (cur_op == OP_SPAWN) begin
            kind <= K_SPAWN;
            slot <= idx;
            pos_x <= sx;
            pos_y <= sy;
            pos_z <= sz;
            gray <= g_c;
          end else if (found) begin
            kind <= K_REC;
            slot <= hold_slot;
            pos_x <= hold_x;
            pos_y <= hold_y;
            pos_z <= hold_z;
            gray <= hold_g;
          end else begin
            kind <= K_EMPTY;
            slot <= '0;
            pos_x <= '0;
            pos_y <= '0;
            pos_z <= '0;
            gray <= '0;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

[hw/rtl/ppu_ram.sv]
// ----------------------------------------------------------------------------
// ppu_ram
// generic single port ram with registered read
// ----------------------------------------------------------------------------
module ppu_ram #(
  parameter int Width = 8,
  parameter int Depth = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] addr,
  input  logic [Width-1:0]         wdata,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

[hw/rtl/ppu_checker.sv]
// ----------------------------------------------------------------------------
// ppu_checker
// port level checks of the particle pool
// ----------------------------------------------------------------------------
`include "particle_pool_update_defines.svh"
module ppu_checker (
  input logic       clk,
  input logic       rst,
  input logic       start,
  input logic       busy,
  input logic [1:0] op,
  input logic       strobe,
  input logic [1:0] kind,
  input logic       last,
  input logic       cfg_ready
);
  import ppu_pkg::*;
  `PPU_ASSERT_IMP(a_strobe_busy, clk, rst, strobe && !last, busy)
  `PPU_ASSERT_IMP(a_tick_last, clk, rst, strobe && kind == K_TICK, last)
  `PPU_ASSERT_IMP(a_spawn_last, clk, rst, strobe && kind == K_SPAWN, last)
  `PPU_ASSERT_NXT(a_start_busy, clk, rst, start && !busy && op != OP_NONE, busy && !cfg_ready)
endmodule

bind particle_pool_update ppu_checker u_ppu_checker (
  .clk(clk), .rst(rst), .start(start), .busy(busy), .op(op), .strobe(strobe),
  .kind(kind), .last(last), .cfg_ready(cfg_ready));
